// ===== rtl/core/dtob_pkg.sv =====
// ----------------------------------------------------------------------------
// dtob_pkg: shared definitions of the depth-tested over-blend unit
// Store geometry, field widths, operation and register codes, sequencer states.
// ----------------------------------------------------------------------------
package dtob_pkg;

    // built store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH_BITS = 24;
    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

    // field widths
    localparam int COORD_W    = 16;
    localparam int ZIN_W      = 24;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // one restoring-divider step per cycle, dividend width
    localparam int DIV_STEPS  = 24;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int LANES      = 4;

    // divide by 255 as a reciprocal multiply, exact for dividends below 2**24
    localparam logic [24:0] RECIP_255    = 25'd16843010;
    localparam int          RECIP_SHIFT  = 32;
    localparam int          RECIP_PROD_W = DIV_STEPS + 25;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // operation codes
    localparam logic FUNC_DRAW = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // register indexes and frame-size reset value
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] FRAME_RESET     = 9'd256;

    typedef logic [DEPTH_BITS-1:0] depth_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [COLOR_W-1:0]    color_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TEST,
        ST_MUL,
        ST_DIV1,
        ST_NUM,
        ST_DIV2,
        ST_PACK,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/core/dtob_in_if.sv =====
// ----------------------------------------------------------------------------
// dtob_in_if: pixel operation channel
// Valid/ready channel carrying one pixel operation word.
// ----------------------------------------------------------------------------
interface dtob_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [dtob_pkg::COORD_W-1:0] x_coord;
    logic [dtob_pkg::COORD_W-1:0] y_coord;
    logic [dtob_pkg::ZIN_W-1:0]   pixel_depth;
    logic [dtob_pkg::COLOR_W-1:0] src_color;

    modport source (output valid, func, x_coord, y_coord, pixel_depth, src_color,
                    input ready);
    modport sink   (input valid, func, x_coord, y_coord, pixel_depth, src_color,
                    output ready);
endinterface

// ===== rtl/core/dtob_out_if.sv =====
// ----------------------------------------------------------------------------
// dtob_out_if: pixel result channel
// Valid/ready channel carrying one result word per operation.
// ----------------------------------------------------------------------------
interface dtob_out_if;
    logic                         valid;
    logic                         ready;
    logic [dtob_pkg::COLOR_W-1:0] color_out;
    logic                         written;
    logic                         out_of_frame;

    modport source (output valid, color_out, written, out_of_frame, input ready);
    modport sink   (input valid, color_out, written, out_of_frame, output ready);
endinterface

// ===== rtl/core/dtob_cfg_if.sv =====
// ----------------------------------------------------------------------------
// dtob_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface dtob_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dtob_pkg::CFG_IDX_W-1:0]  index;
    logic [dtob_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dtob_ram.sv =====
// ----------------------------------------------------------------------------
// dtob_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dtob_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/depth_tested_over_blend_write.sv =====
// ----------------------------------------------------------------------------
// depth_tested_over_blend_write: z-buffered alpha-over raster operation unit
// Color and depth stores in RAM, depth test, over blend through a four-lane divider.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both stores, one entry a cycle, writing black and
// the farthest depth into all STORE_SIZE entries (65536 at the built 256 x 256),
// during which no pixel word is taken; register writes are taken at any time.
// Words are then handled one at a time by a read-modify-write sequencer around
// the two RAMs. Out-of-frame words go straight to the result; reads and failed
// depth tests pass through READ and TEST; opaque or transparent draws add WRITE;
// blended draws add MUL, DIV1, NUM, DIV2 and PACK. In a blended draw the divide
// by 255 is a reciprocal multiply, followed by the 24-step pass of the four-lane
// restoring divider that divides by the resulting alpha. The result word sits in
// an output register, so the next pixel word is taken while the previous result waits.
// ----------------------------------------------------------------------------
module depth_tested_over_blend_write (
    input  logic       clk,
    input  logic       rst_n,
    dtob_in_if.sink    pix_in,
    dtob_out_if.source pix_out,
    dtob_cfg_if.sink   cfg
);
    import dtob_pkg::*;

    // control state
    state_t                 state_reg, state_next;
    addr_t                  clr_cnt_reg, clr_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CFG_DATA_W-1:0]  fw_reg, fw_next;
    logic [CFG_DATA_W-1:0]  fh_reg, fh_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    // payload state
    logic                   func_reg, func_next;
    addr_t                  addr_reg, addr_next;
    depth_t                 z_reg, z_next;
    color_t                 src_reg, src_next;
    logic [7:0]             den_reg, den_next;
    logic [DIV_STEPS-1:0]   lane_dvd_reg [LANES];
    logic [DIV_STEPS-1:0]   lane_dvd_next [LANES];
    logic [7:0]             lane_rem_reg [LANES];
    logic [7:0]             lane_rem_next [LANES];
    color_t                 newcol_reg, newcol_next;
    color_t                 res_color_reg, res_color_next;
    logic                   res_written_reg, res_written_next;
    logic                   res_oof_reg, res_oof_next;
    color_t                 out_color_reg, out_color_next;
    logic                   out_written_reg, out_written_next;
    logic                   out_oof_reg, out_oof_next;

    // memory ports
    logic                   mem_we;
    addr_t                  mem_waddr;
    color_t                 color_wdata;
    depth_t                 depth_wdata;
    color_t                 color_rdata;
    depth_t                 depth_rdata;

    // divider step results
    logic [DIV_STEPS-1:0]   step_dvd [LANES];
    logic [7:0]             step_rem [LANES];

    // frame check of the incoming word
    logic [COORD_W-1:0]     w_eff;
    logic [COORD_W-1:0]     h_eff;
    logic                   in_frame;
    addr_t                  in_addr;

    logic                   in_acc;
    logic                   out_acc;
    logic [7:0]             sa;
    logic [7:0]             inv;
    logic [7:0]             da;

    dtob_ram #(.WIDTH(COLOR_W), .DEPTH(STORE_SIZE)) u_color_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (color_wdata),
        .raddr (addr_reg),
        .rdata (color_rdata)
    );

    dtob_ram #(.WIDTH(DEPTH_BITS), .DEPTH(STORE_SIZE)) u_depth_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (depth_wdata),
        .raddr (addr_reg),
        .rdata (depth_rdata)
    );

    // handshakes
    assign pix_in.ready         = (state_reg == ST_IDLE);
    assign cfg.ready            = 1'b1;
    assign in_acc               = pix_in.valid && pix_in.ready;
    assign out_acc              = pix_out.valid && pix_out.ready;
    assign pix_out.valid        = out_valid_reg;
    assign pix_out.color_out    = out_color_reg;
    assign pix_out.written      = out_written_reg;
    assign pix_out.out_of_frame = out_oof_reg;

    // effective frame size, saturated to the built store
    always_comb
    begin
        w_eff = (16'(fw_reg) > 16'(MAX_WIDTH))  ? 16'(MAX_WIDTH)  : 16'(fw_reg);
        h_eff = (16'(fh_reg) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : 16'(fh_reg);
        in_frame = !pix_in.x_coord[COORD_W-1] && !pix_in.y_coord[COORD_W-1]
                && ({1'b0, pix_in.x_coord[COORD_W-2:0]} < w_eff)
                && ({1'b0, pix_in.y_coord[COORD_W-2:0]} < h_eff);
        in_addr = ADDR_W'(32'(pix_in.y_coord[COORD_W-2:0]) * 32'(MAX_WIDTH)
                + 32'(pix_in.x_coord[COORD_W-2:0]));
    end

    // alpha terms
    assign sa  = src_reg[31:24];
    assign inv = 8'(ALPHA_OPAQUE - sa);
    assign da  = color_rdata[31:24];

    // one restoring division step per lane
    always_comb
    begin
        logic [8:0] sh;
        logic       ge;
        for (int i = 0; i < LANES; i++)
        begin
            sh = {lane_rem_reg[i], lane_dvd_reg[i][DIV_STEPS-1]};
            ge = (sh >= {1'b0, den_reg});
            step_rem[i] = ge ? 8'(sh - {1'b0, den_reg}) : sh[7:0];
            step_dvd[i] = {lane_dvd_reg[i][DIV_STEPS-2:0], ge};
        end
    end

    // sequencer: next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg;
        fw_next          = fw_reg;
        fh_next          = fh_reg;
        cnt_next         = cnt_reg;
        func_next        = func_reg;
        addr_next        = addr_reg;
        z_next           = z_reg;
        src_next         = src_reg;
        den_next         = den_reg;
        lane_dvd_next    = lane_dvd_reg;
        lane_rem_next    = lane_rem_reg;
        newcol_next      = newcol_reg;
        res_color_next   = res_color_reg;
        res_written_next = res_written_reg;
        res_oof_next     = res_oof_reg;
        out_color_next   = out_color_reg;
        out_written_next = out_written_reg;
        out_oof_next     = out_oof_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        color_wdata      = newcol_reg;
        depth_wdata      = z_reg;

        // register writes
        if (cfg.valid)
        begin
            if (cfg.index == CFG_FRAME_WIDTH)
            begin
                fw_next = cfg.data;
            end
            else if (cfg.index == CFG_FRAME_HEIGHT)
            begin
                fh_next = cfg.data;
            end
        end

        // output register drains
        if (out_acc)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = clr_cnt_reg;
                color_wdata = '0;
                depth_wdata = '1;
                clr_cnt_next = ADDR_W'(32'(clr_cnt_reg) + 1);
                if (32'(clr_cnt_reg) == STORE_SIZE - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    func_next = pix_in.func;
                    addr_next = in_addr;
                    z_next    = DEPTH_BITS'(pix_in.pixel_depth);
                    src_next  = pix_in.src_color;
                    if (in_frame)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        res_color_next   = '0;
                        res_written_next = 1'b0;
                        res_oof_next     = 1'b1;
                        state_next       = ST_DONE;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                res_oof_next = 1'b0;
                if (func_reg == FUNC_DRAW && z_reg < depth_rdata)
                begin
                    priority if (sa == ALPHA_OPAQUE)
                    begin
                        newcol_next = src_reg;
                        state_next  = ST_WRITE;
                    end
                    else if (sa == ALPHA_CLEAR)
                    begin
                        newcol_next = color_rdata;
                        state_next  = ST_WRITE;
                    end
                    else
                    begin
                        // first products: da*inv and dc*da per channel
                        lane_dvd_next[0] = DIV_STEPS'(da * inv);
                        for (int i = 1; i < LANES; i++)
                        begin
                            lane_dvd_next[i] = DIV_STEPS'(color_rdata[8*(3-i) +: 8] * da);
                        end
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    res_color_next   = color_rdata;
                    res_written_next = 1'b0;
                    state_next       = ST_DONE;
                end
            end
            ST_MUL:
            begin
                // dc*da*inv per channel
                for (int i = 1; i < LANES; i++)
                begin
                    lane_dvd_next[i] = DIV_STEPS'(lane_dvd_reg[i][15:0] * inv);
                end
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                // all lanes divided by 255 through the reciprocal
                for (int i = 0; i < LANES; i++)
                begin
                    lane_dvd_next[i] = DIV_STEPS'((RECIP_PROD_W'(lane_dvd_reg[i])
                                     * RECIP_PROD_W'(RECIP_255)) >> RECIP_SHIFT);
                end
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                // result alpha and per-channel numerators
                den_next = 8'(sa + lane_dvd_reg[0][7:0]);
                for (int i = 1; i < LANES; i++)
                begin
                    lane_dvd_next[i] = DIV_STEPS'(src_reg[8*(3-i) +: 8] * sa)
                                     + lane_dvd_reg[i];
                end
                for (int i = 0; i < LANES; i++)
                begin
                    lane_rem_next[i] = '0;
                end
                cnt_next   = '0;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                lane_dvd_next = step_dvd;
                lane_rem_next = step_rem;
                cnt_next      = DIV_CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                newcol_next = {den_reg, lane_dvd_reg[1][7:0], lane_dvd_reg[2][7:0],
                               lane_dvd_reg[3][7:0]};
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                mem_we           = 1'b1;
                res_color_next   = newcol_reg;
                res_written_next = 1'b1;
                state_next       = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_acc)
                begin
                    out_valid_next   = 1'b1;
                    out_color_next   = res_color_reg;
                    out_written_next = res_written_reg;
                    out_oof_next     = res_oof_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            fw_reg        <= FRAME_RESET;
            fh_reg        <= FRAME_RESET;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg        <= func_next;
        addr_reg        <= addr_next;
        z_reg           <= z_next;
        src_reg         <= src_next;
        den_reg         <= den_next;
        lane_dvd_reg    <= lane_dvd_next;
        lane_rem_reg    <= lane_rem_next;
        newcol_reg      <= newcol_next;
        res_color_reg   <= res_color_next;
        res_written_reg <= res_written_next;
        res_oof_reg     <= res_oof_next;
        out_color_reg   <= out_color_next;
        out_written_reg <= out_written_next;
        out_oof_reg     <= out_oof_next;
    end

`ifndef NO_ASSERTIONS
    // an accepted word goes to the store read or straight to the result
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == ST_READ || state_reg == ST_DONE))
        else $error("accepted word did not start a read or a result");

    // stores are written only by the clear sweep or the write-back step
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_WRITE || state_reg == ST_CLEAR))
        else $error("store write outside clear or write-back");

    // a written word was inside the frame
    a_written_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> !(pix_out.written && pix_out.out_of_frame))
        else $error("result marked written and out of frame");

    // out-of-frame results carry black
    a_oof_black: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && pix_out.out_of_frame) |-> (pix_out.color_out == '0))
        else $error("out-of-frame result with nonzero color");
`endif

endmodule
